// ----- rtl/hss_pkg.sv -----
package hss_pkg;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_DRIVE = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  localparam logic [3:0] MAX_SPEED    = 4'd8;
  localparam logic [7:0] PERIOD_RESET = 8'd255;

  typedef struct packed {
    logic [3:0] coils;
    logic       running;
    logic [2:0] phase;
  } status_t;

  // half-step pattern: A, AB, B, BC, C, CD, D, DA
  function automatic logic [3:0] coil_pattern(input logic [2:0] ph);
    logic [3:0] pat;
    case (ph)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

// ----- rtl/hss_seq.sv -----
module hss_seq #(
  parameter int STEP_COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_data,
  input  logic                       accept,
  input  logic [1:0]                 req_type,
  input  logic [7:0]                 speed,
  input  logic                       direction,
  input  logic                       continuous,
  input  logic [15:0]                full_steps,
  output hss_pkg::status_t           status_next,
  output logic [STEP_COUNT_BITS-1:0] count_next
);

  logic                       default_direction;
  logic                       run_flag;
  logic                       forever_flag;
  logic [2:0]                 phase_index;
  logic [STEP_COUNT_BITS-1:0] step_count;
  logic                       turn_dir;
  logic [7:0]                 period_value;
  logic [7:0]                 tick_count;
  logic [3:0]                 coil_bits;

  logic                       run_flag_next;
  logic                       forever_flag_next;
  logic [2:0]                 phase_index_next;
  logic [STEP_COUNT_BITS-1:0] step_count_next;
  logic                       turn_dir_next;
  logic [7:0]                 period_value_next;
  logic [7:0]                 tick_count_next;
  logic [3:0]                 coil_bits_next;

  logic [8:0]  tick_sum;
  logic        period_match;
  logic        wrapped;
  logic        upward;
  logic [3:0]  speed_clamped;
  logic [31:0] steps_ext;

  assign tick_sum      = {1'b0, tick_count} + 9'd1;
  assign period_match  = tick_sum >= {1'b0, period_value};
  assign upward        = (turn_dir == default_direction);
  assign wrapped       = upward ? (phase_index == 3'd7) : (phase_index == 3'd0);
  assign speed_clamped = (speed > 8'(hss_pkg::MAX_SPEED)) ? hss_pkg::MAX_SPEED : speed[3:0];
  assign steps_ext     = 32'(full_steps);

  always_comb begin
    run_flag_next     = run_flag;
    forever_flag_next = forever_flag;
    phase_index_next  = phase_index;
    step_count_next   = step_count;
    turn_dir_next     = turn_dir;
    period_value_next = period_value;
    tick_count_next   = tick_count;
    coil_bits_next    = coil_bits;
    case (req_type)
      hss_pkg::REQ_TICK: begin
        if (run_flag) begin
          if (period_match) begin
            tick_count_next = 8'd0;
            if (!forever_flag && step_count == '0) begin
              // count used up: stop without a further step
              run_flag_next     = 1'b0;
              forever_flag_next = 1'b0;
              phase_index_next  = 3'd0;
              step_count_next   = '0;
              coil_bits_next    = 4'd0;
            end else begin
              phase_index_next = upward ? phase_index + 3'd1 : phase_index - 3'd1;
              if (wrapped && !forever_flag) begin
                step_count_next = step_count - STEP_COUNT_BITS'(1);
              end
              coil_bits_next = hss_pkg::coil_pattern(phase_index_next);
            end
          end else begin
            tick_count_next = tick_count + 8'd1;
          end
        end
      end
      hss_pkg::REQ_DRIVE: begin
        turn_dir_next = direction;
        if (speed == 8'd0) begin
          run_flag_next     = 1'b0;
          forever_flag_next = 1'b0;
          phase_index_next  = 3'd0;
          step_count_next   = '0;
          tick_count_next   = 8'd0;
          coil_bits_next    = 4'd0;
        end else begin
          // period of 2^(speed-1)+1 ticks, with speed clamped to MAX_SPEED
          period_value_next = (8'd1 << (speed_clamped - 4'd1)) + 8'd1;
          tick_count_next   = 8'd0;
          phase_index_next  = 3'd0;
          run_flag_next     = 1'b1;
          forever_flag_next = continuous;
          step_count_next   = continuous ? '0 : steps_ext[STEP_COUNT_BITS-1:0];
        end
      end
      hss_pkg::REQ_STOP: begin
        run_flag_next     = 1'b0;
        forever_flag_next = 1'b0;
        phase_index_next  = 3'd0;
        step_count_next   = '0;
        tick_count_next   = 8'd0;
        coil_bits_next    = 4'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_direction <= 1'b0;
    end else if (cfg_we) begin
      default_direction <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag     <= 1'b0;
      forever_flag <= 1'b0;
      phase_index  <= 3'd0;
      step_count   <= '0;
      turn_dir     <= 1'b0;
      period_value <= hss_pkg::PERIOD_RESET;
      tick_count   <= 8'd0;
      coil_bits    <= 4'd0;
    end else if (accept) begin
      run_flag     <= run_flag_next;
      forever_flag <= forever_flag_next;
      phase_index  <= phase_index_next;
      step_count   <= step_count_next;
      turn_dir     <= turn_dir_next;
      period_value <= period_value_next;
      tick_count   <= tick_count_next;
      coil_bits    <= coil_bits_next;
    end
  end

  assign status_next.coils   = coil_bits_next;
  assign status_next.running = run_flag_next;
  assign status_next.phase   = phase_index_next;
  assign count_next          = step_count_next;

`ifndef SYNTHESIS
  a_idle_coils_off: assert property (@(posedge clk) disable iff (rst)
    !run_flag |-> (coil_bits == 4'd0 && phase_index == 3'd0 && step_count == '0))
    else $error("coils or phase left set while stopped");

  a_forever_no_count: assert property (@(posedge clk) disable iff (rst)
    forever_flag |-> (step_count == '0 && run_flag))
    else $error("continuous mode with a step count");

  a_period_legal: assert property (@(posedge clk) disable iff (rst)
    period_value == 8'd2 || period_value == 8'd3 || period_value == 8'd5 ||
    period_value == 8'd9 || period_value == 8'd17 || period_value == 8'd33 ||
    period_value == 8'd65 || period_value == 8'd129 || period_value == 8'd255)
    else $error("tick period outside the speed table");
`endif

endmodule

// ----- rtl/half_step_stepper_sequencer_top.sv -----
// half-step sequencer for the four coils of a unipolar stepper
// input channel (in_valid/in_ready) carries one request per transaction:
//   tick advances the prescaler while running, drive starts the motor at a
//   given speed, direction and step count (speed 0 stops it), stop turns the coils off
// output channel (out_valid/out_ready) returns one result per request: the
// coil bits, running flag, phase and remaining step count after the update
// out_valid rises in the cycle after acceptance; one request is taken
// every cycle as long as the receiver keeps up, since the state update is a
// single pass of logic into the state and result registers
// when the receiver stalls, the result register holds its transaction and
// in_ready stays low until it is taken
// cfg_we writes default_direction at any clock edge; it is meant to change
// only while no transaction is in flight
// synchronous reset stops the motor, clears phase, count and coils, sets the
// tick period to 255 and default_direction to 0, and empties the output
module half_step_stepper_sequencer_top #(
  parameter int STEP_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  speed,
  input  logic        direction,
  input  logic        continuous,
  input  logic [15:0] full_steps,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  coils,
  output logic        running,
  output logic [2:0]  phase,
  output logic [15:0] steps_left
);

  logic                       accept;
  hss_pkg::status_t           status_next;
  logic [STEP_COUNT_BITS-1:0] count_next;
  logic [31:0]                count_ext;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign count_ext = 32'(count_next);

  hss_seq #(
    .STEP_COUNT_BITS(STEP_COUNT_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .req_type   (req_type),
    .speed      (speed),
    .direction  (direction),
    .continuous (continuous),
    .full_steps (full_steps),
    .status_next(status_next),
    .count_next (count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, loaded with the state after the update
  always_ff @(posedge clk) begin
    if (accept) begin
      coils      <= status_next.coils;
      running    <= status_next.running;
      phase      <= status_next.phase;
      steps_left <= count_ext[15:0];
    end
  end

endmodule
